FILE: design/buh_pkg.sv
// Package for the bounded undo/redo position history.
// Holds command and outcome codes, fixed field widths and the control structs.
// No dependencies.
package buh_pkg;

    localparam int CMD_W     = 2;
    localparam int OUTCOME_W = 2;
    localparam int CFG_W     = 6;
    localparam int ENTRY_W   = 6;

    // limit after reset
    localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 6'd20;

    typedef enum logic [CMD_W-1:0] {
        CMD_JUMP = 2'd0,
        CMD_UNDO = 2'd1,
        CMD_REDO = 2'd2
    } cmd_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_IGNORED  = 2'd0,
        OUT_RECORDED = 2'd1,
        OUT_BACK     = 2'd2,
        OUT_FORWARD  = 2'd3
    } outcome_t;

    // status that travels with a result beat
    typedef struct packed {
        outcome_t outcome;
        logic     can_undo;
        logic     can_redo;
    } res_flags_t;

    // per-command control from the step logic
    typedef struct packed {
        res_flags_t res;
        logic       wr_en;
        logic       rd_en;
    } step_ctrl_t;

endpackage

FILE: design/buh_store.sv
// Position store: ring of history slots, one write and one registered read per cycle.
// Depends on nothing but its parameters.
module buh_store #(
    parameter int DEPTH  = 32,
    parameter int DATA_W = 40,
    localparam int SLOT_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_slot,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              load,     // capture new read data
    input  logic              rd_en,    // read the slot, else capture zero
    input  logic [SLOT_W-1:0] rd_slot,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slot] <= wr_data;
        end
    end

    // write and read slots of one command never coincide
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rd_data_reg <= rd_en ? mem[rd_slot] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/buh_step.sv
// Next-state logic for one history command: ring pointer, count, cursor, slots.
// Depends on buh_pkg.
module buh_step #(
    parameter int DEPTH = 32,
    localparam int SLOT_W = $clog2(DEPTH),
    localparam int CNT_W  = $clog2(DEPTH + 1),
    localparam int CUR_W  = CNT_W + 2
) (
    input  buh_pkg::cmd_t             cmd,
    input  logic                      view_empty,
    input  logic [SLOT_W-1:0]         oldest,
    input  logic [CNT_W-1:0]          held,
    input  logic signed [CUR_W-1:0]   cursor,
    input  logic [CNT_W-1:0]          lim,
    output logic [SLOT_W-1:0]         oldest_next,
    output logic [CNT_W-1:0]          held_next,
    output logic signed [CUR_W-1:0]   cursor_next,
    output logic [SLOT_W-1:0]         wr_slot,
    output logic [SLOT_W-1:0]         rd_slot,
    output buh_pkg::step_ctrl_t       ctrl
);

    import buh_pkg::*;

    localparam logic [CNT_W:0] DEPTH_S = (CNT_W + 1)'(DEPTH);

    function automatic logic [SLOT_W-1:0] wrap(input logic [CNT_W:0] s);
        logic [CNT_W:0] r;
        r = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
        return r[SLOT_W-1:0];
    endfunction

    logic signed [CUR_W-1:0] held_s;
    logic signed [CUR_W-1:0] cplus;
    logic                    undo_ok;
    logic                    redo_ok;

    // shared append path
    logic [CNT_W-1:0]        base;
    logic [CNT_W:0]          cnt;
    logic [CNT_W:0]          drop;
    logic                    over;
    logic signed [CUR_W-1:0] drop_s;
    logic [SLOT_W-1:0]       app_oldest;
    logic [CNT_W-1:0]        app_held;
    logic signed [CUR_W-1:0] app_cursor;
    logic [SLOT_W-1:0]       app_slot;

    logic [SLOT_W-1:0]       cur_slot;
    logic [SLOT_W-1:0]       prev_slot;
    logic [SLOT_W-1:0]       next_slot;
    logic signed [CUR_W-1:0] cur_m1;

    assign held_s  = $signed(CUR_W'(held));
    assign cplus   = cursor + CUR_W'(1);
    assign cur_m1  = cursor - CUR_W'(1);
    assign undo_ok = (cursor > 0) && (cursor <= held_s);
    assign redo_ok = cplus < held_s;

    always_comb
    begin
        // a jump first cuts the list at the cursor
        if (cmd == CMD_JUMP && cursor >= 0 && held_s > cursor)
        begin
            base = cursor[CNT_W-1:0];
        end
        else
        begin
            base = held;
        end
        cnt        = {1'b0, base} + (CNT_W + 1)'(1);
        over       = cnt > {1'b0, lim};
        drop       = cnt - {1'b0, lim};
        drop_s     = $signed(CUR_W'(drop));
        app_oldest = over ? wrap((CNT_W + 1)'(oldest) + drop) : oldest;
        app_held   = over ? lim : cnt[CNT_W-1:0];
        if (!over)
        begin
            app_cursor = cursor;
        end
        else if (cursor < 0 || cursor > drop_s)
        begin
            app_cursor = cursor - drop_s;
        end
        else
        begin
            app_cursor = '0;
        end
        app_slot = wrap((CNT_W + 1)'(oldest) + (CNT_W + 1)'(base));
    end

    always_comb
    begin
        // cursor one below zero addresses the slot below the oldest
        if (cursor < 0)
        begin
            cur_slot = (oldest == '0) ? SLOT_W'(DEPTH - 1) : oldest - SLOT_W'(1);
        end
        else
        begin
            cur_slot = wrap((CNT_W + 1)'(oldest) + (CNT_W + 1)'(cursor[CNT_W-1:0]));
        end
        prev_slot = wrap((CNT_W + 1)'(oldest) + (CNT_W + 1)'(cur_m1[CNT_W-1:0]));
        next_slot = wrap((CNT_W + 1)'(oldest) + (CNT_W + 1)'(cplus[CNT_W-1:0]));
    end

    always_comb
    begin
        oldest_next      = oldest;
        held_next        = held;
        cursor_next      = cursor;
        wr_slot          = cur_slot;
        rd_slot          = next_slot;
        ctrl.res.outcome = OUT_IGNORED;
        ctrl.wr_en       = 1'b0;
        ctrl.rd_en       = 1'b0;
        case (cmd)
            CMD_JUMP:
            begin
                if (!view_empty)
                begin
                    oldest_next      = app_oldest;
                    held_next        = app_held;
                    cursor_next      = app_cursor + CUR_W'(1);
                    wr_slot          = app_slot;
                    ctrl.wr_en       = 1'b1;
                    ctrl.res.outcome = OUT_RECORDED;
                end
            end
            CMD_UNDO:
            begin
                if (!view_empty && undo_ok)
                begin
                    ctrl.wr_en       = 1'b1;
                    ctrl.rd_en       = 1'b1;
                    rd_slot          = prev_slot;
                    ctrl.res.outcome = OUT_BACK;
                    if (cursor == held_s)
                    begin
                        // at the top: save the current position as a new entry
                        oldest_next = app_oldest;
                        held_next   = app_held;
                        cursor_next = app_cursor - CUR_W'(1);
                        wr_slot     = app_slot;
                    end
                    else
                    begin
                        cursor_next = cur_m1;
                    end
                end
            end
            CMD_REDO:
            begin
                if (!view_empty && redo_ok)
                begin
                    ctrl.wr_en       = 1'b1;
                    ctrl.rd_en       = 1'b1;
                    rd_slot          = next_slot;
                    cursor_next      = cplus;
                    ctrl.res.outcome = OUT_FORWARD;
                    // landing one below the last entry drops it
                    if (cplus + CUR_W'(1) == held_s)
                    begin
                        held_next = held - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                ctrl.res.outcome = OUT_IGNORED;
            end
        endcase
        ctrl.res.can_undo = (cursor_next > 0) && (cursor_next <= $signed(CUR_W'(held_next)));
        ctrl.res.can_redo = (cursor_next + CUR_W'(1)) < $signed(CUR_W'(held_next));
    end

endmodule

FILE: design/bounded_undo_redo_position_history.sv
// Top level of the bounded undo/redo position history.
// Input register, step logic (buh_step), position store (buh_store), result register.
// Depends on buh_pkg, buh_step, buh_store.
//
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    tdata: cur_paragraph, cur_word; tuser: command, view_empty
//  m_*      out  m_tvalid / m_tready    tdata: target pos, can_undo, can_redo, entry_count;
//                                       tuser: outcome
//  cfg_*    in   cfg_wen                cfg_wdata: max_entries
//
// One beat per cycle sustained while m_tready stays high; the command beat is first captured
// in the input register, then the state update and the registered store read land in the
// result register at the same edge.
// Reset clears the valid bits, ring pointer, count and cursor and sets the limit to 20;
// the store is not cleared (entries outside the held list are never read).
// A stalled m_tready holds the result beat; s_tready drops only once the input register
// is also full.
module bounded_undo_redo_position_history #(
    parameter int HISTORY_DEPTH  = 32,
    parameter int PARAGRAPH_BITS = 24,
    parameter int WORD_BITS      = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      cfg_wen,
    input  logic [buh_pkg::CFG_W-1:0] cfg_wdata,     // max_entries
    // command beats
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // [PARAGRAPH_BITS-1:0] cur_paragraph, then cur_word, zero pad to bytes
    input  logic [((PARAGRAPH_BITS + WORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // [1:0] command, [2] view_empty
    input  logic [buh_pkg::CMD_W:0]   s_tuser,
    // result beats
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // target_paragraph, target_word, can_undo, can_redo, entry_count, zero pad to bytes
    output logic [((PARAGRAPH_BITS + WORD_BITS + 2 + buh_pkg::ENTRY_W + 7) / 8) * 8 - 1:0]
                                      m_tdata,
    // [1:0] outcome
    output logic [buh_pkg::OUTCOME_W-1:0] m_tuser
);

    import buh_pkg::*;

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int CUR_W  = CNT_W + 2;
    localparam int POS_W  = PARAGRAPH_BITS + WORD_BITS;
    localparam int OUT_W  = ((POS_W + 2 + ENTRY_W + 7) / 8) * 8;
    localparam int LIM_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // configuration register and effective limit (zero reads as one, clipped to depth)
    logic [CFG_W-1:0] max_entries_reg;
    logic [LIM_W-1:0] cfg_ext;
    logic [CNT_W-1:0] lim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_ENTRIES_RESET;
        end
        else if (cfg_wen)
        begin
            max_entries_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        cfg_ext = LIM_W'(max_entries_reg);
        if (cfg_ext == '0)
        begin
            lim = CNT_W'(1);
        end
        else if (cfg_ext > LIM_W'(HISTORY_DEPTH))
        begin
            lim = CNT_W'(HISTORY_DEPTH);
        end
        else
        begin
            lim = cfg_ext[CNT_W-1:0];
        end
    end

    // handshake: input register feeds the result register
    logic a_valid_reg;
    logic b_valid_reg;
    logic b_load;
    logic a_fire;
    logic in_fire;

    assign b_load   = !b_valid_reg || m_tready;
    assign a_fire   = a_valid_reg && b_load;
    assign s_tready = !a_valid_reg || b_load;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = b_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_fire)
            begin
                a_valid_reg <= 1'b0;
            end
            if (b_load)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // input register payload
    logic [CMD_W-1:0]          a_cmd_reg;
    logic                      a_empty_reg;
    logic [PARAGRAPH_BITS-1:0] a_par_reg;
    logic [WORD_BITS-1:0]      a_word_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_cmd_reg   <= s_tuser[CMD_W-1:0];
            a_empty_reg <= s_tuser[CMD_W];
            a_par_reg   <= s_tdata[PARAGRAPH_BITS-1:0];
            a_word_reg  <= s_tdata[PARAGRAPH_BITS +: WORD_BITS];
        end
    end

    // history state: ring pointer to oldest slot, held count, cursor
    // (cursor may sit one below zero after an undo at a limit of one)
    logic [SLOT_W-1:0]       oldest_reg;
    logic [CNT_W-1:0]        held_reg;
    logic signed [CUR_W-1:0] cursor_reg;
    logic [SLOT_W-1:0]       oldest_next;
    logic [CNT_W-1:0]        held_next;
    logic signed [CUR_W-1:0] cursor_next;
    logic [SLOT_W-1:0]       wr_slot;
    logic [SLOT_W-1:0]       rd_slot;
    step_ctrl_t              ctrl;

    buh_step #(
        .DEPTH (HISTORY_DEPTH)
    ) u_step (
        .cmd         (cmd_t'(a_cmd_reg)),
        .view_empty  (a_empty_reg),
        .oldest      (oldest_reg),
        .held        (held_reg),
        .cursor      (cursor_reg),
        .lim         (lim),
        .oldest_next (oldest_next),
        .held_next   (held_next),
        .cursor_next (cursor_next),
        .wr_slot     (wr_slot),
        .rd_slot     (rd_slot),
        .ctrl        (ctrl)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            held_reg   <= '0;
            cursor_reg <= '0;
        end
        else if (a_fire)
        begin
            oldest_reg <= oldest_next;
            held_reg   <= held_next;
            cursor_reg <= cursor_next;
        end
    end

    // position store; its read register is part of the result register
    logic [POS_W-1:0] rd_data;

    buh_store #(
        .DEPTH  (HISTORY_DEPTH),
        .DATA_W (POS_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (a_fire && ctrl.wr_en),
        .wr_slot (wr_slot),
        .wr_data ({a_word_reg, a_par_reg}),
        .load    (a_fire),
        .rd_en   (ctrl.rd_en),
        .rd_slot (rd_slot),
        .rd_data (rd_data)
    );

    // result register
    res_flags_t         b_flags_reg;
    logic [ENTRY_W-1:0] b_count_reg;

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            b_flags_reg <= ctrl.res;
            b_count_reg <= ENTRY_W'(held_next);
        end
    end

    assign m_tdata = OUT_W'({b_count_reg, b_flags_reg.can_redo, b_flags_reg.can_undo, rd_data});
    assign m_tuser = b_flags_reg.outcome;

    // cursor never passes the held count, except one below zero with a single entry
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_reg >= 0 && cursor_reg <= $signed(CUR_W'(held_reg)))
        || (cursor_reg == -1 && held_reg == CNT_W'(1)))
        else $error("cursor out of range");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(HISTORY_DEPTH))
        else $error("held count above depth");

    // a command on an empty view leaves the history untouched
    a_empty_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (a_fire && a_empty_reg) |=>
        ($stable(held_reg) && $stable(cursor_reg) && $stable(oldest_reg)))
        else $error("history changed on empty view");

    // only undo and redo report a target position
    a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == OUT_IGNORED || m_tuser == OUT_RECORDED))
        |-> (m_tdata[POS_W-1:0] == '0))
        else $error("target reported without a move");

endmodule
